>>> design/dwwa_pkg.sv
// Shared types and constants of the dual-wavelength window average block.
// Holds the beat payload structs, the lane control struct and the register map.
// No dependencies.
`default_nettype none

package dwwa_pkg;

    // Sample width of every ADC channel and of every average.
    localparam int SAMPLE_W = 24;
    localparam int CHANNELS = 4;

    // Configuration register map.
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int WL_W     = 7;
    localparam logic [WL_W-1:0] WL_RESET = 7'd16;
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_ch0;
        logic signed [SAMPLE_W-1:0] sample_ch1;
        logic signed [SAMPLE_W-1:0] sample_ch2;
        logic signed [SAMPLE_W-1:0] sample_ch3;
    } in_beat_t;

    typedef struct packed {
        logic                       wavelength_done;
        logic signed [SAMPLE_W-1:0] average_ch0;
        logic signed [SAMPLE_W-1:0] average_ch1;
        logic signed [SAMPLE_W-1:0] average_ch2;
        logic signed [SAMPLE_W-1:0] average_ch3;
    } out_beat_t;

    // Control that the sequencer sends to all lanes alike.
    typedef struct packed {
        logic wr_en;
        logic wr_zero;
        logic rd_en;
        logic acc_clear;
        logic div_start;
    } lane_ctrl_t;

endpackage

`default_nettype wire

>>> design/dwwa_div.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Divides a signed window sum by a positive window length. Uses dwwa_pkg.
`default_nettype none

module dwwa_div #(
    parameter int SUM_W = 31,
    parameter int LEN_W = 7
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic signed [SUM_W-1:0]               dividend,
    input  wire logic        [LEN_W-1:0]               divisor,
    output logic signed      [dwwa_pkg::SAMPLE_W-1:0]  quotient,
    output logic                                       done
);
    import dwwa_pkg::*;

    localparam int CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             neg_reg, neg_next;
    logic [LEN_W:0]   shifted;
    logic [LEN_W:0]   diff;
    logic [SUM_W-1:0] result;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        neg_next  = neg_reg;
        shifted   = {rem_reg, quo_reg[SUM_W-1]};
        diff      = shifted - {1'b0, divisor};
        if (start)
        begin
            neg_next  = dividend[SUM_W-1];
            quo_next  = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(SUM_W - 1);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            // A clear top bit of the difference means the trial subtract fits.
            if (!diff[LEN_W])
            begin
                rem_next = diff[LEN_W-1:0];
            end
            else
            begin
                rem_next = shifted[LEN_W-1:0];
            end
            quo_next = {quo_reg[SUM_W-2:0], ~diff[LEN_W]};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign result   = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;
    assign quotient = result[SAMPLE_W-1:0];
    assign done     = done_reg;

endmodule

`default_nettype wire

>>> design/dwwa_lane.sv
// One channel lane: sample memory for both wavelengths, window sum and divider.
// Depends on dwwa_pkg and dwwa_div.
`default_nettype none

module dwwa_lane #(
    parameter int ADDR_W = 7,
    parameter int LEN_W  = 7,
    parameter int SUM_W  = 31
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire dwwa_pkg::lane_ctrl_t                  ctrl,
    input  wire logic        [ADDR_W-1:0]              addr,
    input  wire logic signed [dwwa_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic        [LEN_W-1:0]               len,
    output logic signed      [dwwa_pkg::SAMPLE_W-1:0]  average,
    output logic                                       done
);
    import dwwa_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic signed [SAMPLE_W-1:0] mem [0:DEPTH-1];
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       rd_valid_reg;
    logic signed [SUM_W-1:0]    acc_reg, acc_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[addr] <= ctrl.wr_zero ? '0 : sample;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.acc_clear)
        begin
            acc_next = '0;
        end
        else if (rd_valid_reg)
        begin
            acc_next = acc_reg + SUM_W'(rd_data_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= ctrl.rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    dwwa_div #(
        .SUM_W (SUM_W),
        .LEN_W (LEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (acc_reg),
        .divisor  (len),
        .quotient (average),
        .done     (done)
    );

endmodule

`default_nettype wire

>>> design/dual_wavelength_window_average.sv
// Top level of the dual-wavelength window average: sequencer, four channel
// lanes, result merging and the configuration port.
// Depends on dwwa_pkg, dwwa_lane and dwwa_div.
//
// Usage. Each input beat on in_data is one four-channel ADC frame; beats
// alternate between the first and second wavelength, starting with the first
// after reset. Each output beat on out_data carries the wavelength whose bank
// the frame updated and the four window averages of that bank. Both channels
// use valid and stall: a beat moves at a rising edge with valid high and
// stall low. The window length is written over the APB port at byte
// address 0 while the block is idle; zero acts as one and values above
// MAX_WINDOW act as MAX_WINDOW.
// An accepted frame passes a write, one memory read per window entry, the
// read pipeline, the serial divide and the output load before its output
// beat is loaded. A frame is taken only while the sequencer is idle, so the
// next frame waits until the previous result is in the output register;
// the memory sweep and the serial divider set the frame rate.
// After reset a clearing pass zeroes every entry of all sample memories,
// during which in_stall is high.
// When the receiver stalls, the finished beat waits in the output register
// and the next frame is still accepted and processed; its result waits in the
// dividers until the output register frees up.
`default_nettype none

module dual_wavelength_window_average #(
    parameter int MAX_WINDOW = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire dwwa_pkg::in_beat_t              in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output dwwa_pkg::out_beat_t                  out_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [dwwa_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [dwwa_pkg::PDATA_W-1:0]    pwdata,
    output logic      [dwwa_pkg::PDATA_W-1:0]    prdata,
    output logic                                 pready
);
    import dwwa_pkg::*;

    // Slot index, window length and sum widths all follow from MAX_WINDOW.
    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int ADDR_W = SLOT_W + 1;
    localparam int LEN_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW + 1) : 1;
    localparam int SUM_W  = SAMPLE_W + SLOT_W + 1;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_WRITE  = 7'b0000100,
        ST_SUM    = 7'b0001000,
        ST_DRAIN  = 7'b0010000,
        ST_START  = 7'b0100000,
        ST_DIVIDE = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [WL_W-1:0]   window_length_reg, window_length_next;
    logic [SLOT_W-1:0] write_slot_reg [0:1];
    logic [SLOT_W-1:0] write_slot_next [0:1];
    logic              cur_wl_reg, cur_wl_next;
    logic              bank_reg, bank_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [ADDR_W-1:0] clr_idx_reg, clr_idx_next;
    in_beat_t          in_beat_reg, in_beat_next;
    logic              out_valid_reg, out_valid_next;
    out_beat_t         out_beat_reg, out_beat_next;

    logic [LEN_W-1:0]           len;
    logic                       in_take;
    logic                       cfg_write;
    logic [SLOT_W-1:0]          slot_raw;
    logic [LEN_W-1:0]           slot_inc;
    lane_ctrl_t                 ctrl;
    logic [ADDR_W-1:0]          lane_addr;
    logic signed [SAMPLE_W-1:0] lane_sample [0:CHANNELS-1];
    logic signed [SAMPLE_W-1:0] lane_avg [0:CHANNELS-1];
    logic [CHANNELS-1:0]        lane_done;

    // Effective window length: zero counts as one, and MAX_WINDOW caps it.
    always_comb
    begin
        if (window_length_reg == '0)
        begin
            len = LEN_W'(1);
        end
        else if (int'(window_length_reg) > MAX_WINDOW)
        begin
            len = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            len = LEN_W'(window_length_reg);
        end
    end

    // Configuration port. Only the window length register is implemented.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_WINDOW_LENGTH) ? PDATA_W'(window_length_reg) : '0;

    always_comb
    begin
        window_length_next = window_length_reg;
        if (cfg_write && (paddr[2] == REG_WINDOW_LENGTH))
        begin
            window_length_next = pwdata[WL_W-1:0];
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign slot_raw = write_slot_reg[cur_wl_reg];
    assign slot_inc = LEN_W'(slot_reg) + LEN_W'(1);

    // Sequencer: clearing pass, then per frame a write, a window sweep,
    // the divide, and the hand-over of the result to the output register.
    always_comb
    begin
        state_next         = state_reg;
        write_slot_next[0] = write_slot_reg[0];
        write_slot_next[1] = write_slot_reg[1];
        cur_wl_next        = cur_wl_reg;
        bank_next          = bank_reg;
        slot_next          = slot_reg;
        rd_idx_next        = rd_idx_reg;
        clr_idx_next       = clr_idx_reg;
        in_beat_next       = in_beat_reg;
        out_valid_next     = out_valid_reg;
        out_beat_next      = out_beat_reg;
        ctrl               = '0;
        lane_addr          = {bank_reg, slot_reg};

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ctrl.wr_en   = 1'b1;
                ctrl.wr_zero = 1'b1;
                lane_addr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + ADDR_W'(1);
                if (&clr_idx_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_take)
                begin
                    in_beat_next = in_data;
                    bank_next    = cur_wl_reg;
                    cur_wl_next  = ~cur_wl_reg;
                    // A slot left beyond a shrunken window wraps to the start.
                    slot_next    = (LEN_W'(slot_raw) >= len) ? '0 : slot_raw;
                    state_next   = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                ctrl.wr_en     = 1'b1;
                ctrl.acc_clear = 1'b1;
                write_slot_next[bank_reg] =
                    (slot_inc >= len) ? '0 : slot_inc[SLOT_W-1:0];
                rd_idx_next    = '0;
                state_next     = ST_SUM;
            end
            ST_SUM:
            begin
                ctrl.rd_en = 1'b1;
                lane_addr  = {bank_reg, rd_idx_reg};
                if (LEN_W'(rd_idx_reg) + LEN_W'(1) == len)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + SLOT_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_START;
            end
            ST_START:
            begin
                ctrl.div_start = 1'b1;
                state_next     = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                // Merge the four lane results into one output beat.
                if ((&lane_done) && (!out_valid_reg || !out_stall))
                begin
                    out_valid_next                = 1'b1;
                    out_beat_next.wavelength_done = bank_reg;
                    out_beat_next.average_ch0     = lane_avg[0];
                    out_beat_next.average_ch1     = lane_avg[1];
                    out_beat_next.average_ch2     = lane_avg[2];
                    out_beat_next.average_ch3     = lane_avg[3];
                    state_next                    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            window_length_reg <= WL_RESET;
            write_slot_reg[0] <= '0;
            write_slot_reg[1] <= '0;
            cur_wl_reg        <= 1'b0;
            clr_idx_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            window_length_reg <= window_length_next;
            write_slot_reg[0] <= write_slot_next[0];
            write_slot_reg[1] <= write_slot_next[1];
            cur_wl_reg        <= cur_wl_next;
            clr_idx_reg       <= clr_idx_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bank_reg     <= bank_next;
        slot_reg     <= slot_next;
        rd_idx_reg   <= rd_idx_next;
        in_beat_reg  <= in_beat_next;
        out_beat_reg <= out_beat_next;
    end

    assign lane_sample[0] = in_beat_reg.sample_ch0;
    assign lane_sample[1] = in_beat_reg.sample_ch1;
    assign lane_sample[2] = in_beat_reg.sample_ch2;
    assign lane_sample[3] = in_beat_reg.sample_ch3;

    for (genvar ch = 0; ch < CHANNELS; ch++)
    begin : g_lane
        dwwa_lane #(
            .ADDR_W (ADDR_W),
            .LEN_W  (LEN_W),
            .SUM_W  (SUM_W)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .addr    (lane_addr),
            .sample  (lane_sample[ch]),
            .len     (len),
            .average (lane_avg[ch]),
            .done    (lane_done[ch])
        );
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_beat_reg;

    // All lanes run in lock step, so their dividers finish together.
    assert property (@(posedge clk) disable iff (!rst_n)
        (lane_done == '0) || (lane_done == '1))
        else $error("lane dividers out of step");

    // Every accepted frame switches the wavelength for the next one.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (cur_wl_reg != $past(cur_wl_reg)))
        else $error("wavelength did not toggle after a frame");

    // The window sweep never reads past the effective window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> (LEN_W'(rd_idx_reg) < len))
        else $error("window sweep beyond window length");

    // A result is handed over only once the dividers have finished.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg) && $past(state_reg == ST_DIVIDE)) |-> $past(&lane_done))
        else $error("result loaded before divide finished");

endmodule

`default_nettype wire
